// ===== rtl/core/slx_pkg.sv =====
package slx_pkg;

  localparam int unsigned POS_WIDTH       = 16;
  localparam int unsigned KEYWORD_MAX_LEN = 6;
  localparam int unsigned INT_BITS        = 31;
  localparam int unsigned MAX_SLOTS       = 3;
  localparam int unsigned NUM_KW          = 20;

  localparam logic [INT_BITS-1:0] INT_MAX_VAL = '1;
  localparam logic [POS_WIDTH-1:0] LINE_MAX   = '1;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_INTEGER = 6'd21;
  localparam logic [5:0] K_FLOAT   = 6'd22;
  localparam logic [5:0] K_KW0     = 6'd23;
  localparam logic [5:0] K_END     = 6'd43;
  localparam logic [5:0] K_ERROR   = 6'd44;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'("and"), 48'("class"), 48'("else"), 48'("false"), 48'("for"),
    48'("fun"), 48'("if"), 48'("NOV"), 48'("or"), 48'("print"),
    48'("return"), 48'("super"), 48'("this"), 48'("self"), 48'("true"),
    48'("bool"), 48'("int"), 48'("float"), 48'("string"), 48'("while")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd5,
    3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd6, 3'd5
  };

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_COMMENT, M_STRING, M_INT, M_INT_DOT, M_FRAC, M_IDENT
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } lex_in_t;

  typedef struct packed {
    logic [5:0]           token_kind;
    logic [POS_WIDTH-1:0] start_pos;
    logic [POS_WIDTH-1:0] lexeme_length;
    logic [POS_WIDTH-1:0] line_number;
    logic [INT_BITS-1:0]  int_value;
    logic                 value_overflow;
    logic [1:0]           error_code;
    logic                 last_of_run;
  } lex_out_t;

  typedef struct packed {
    logic [1:0]                   count;
    lex_out_t [MAX_SLOTS-1:0]     slots;
  } bundle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] op);
    logic [5:0] k;
    case (op)
      CH_BANG:  k = K_BANG;
      CH_EQUAL: k = K_EQUAL;
      CH_GREAT: k = K_GREATER;
      CH_LESS:  k = K_LESS;
      default:  k = K_SLASH;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kw_byte(int unsigned i, int unsigned j);
    return KW_TEXT[i][8*(int'(KW_LEN[i])-1-int'(j)) +: 8];
  endfunction

endpackage

// ===== rtl/core/source_lexer_core.sv =====
// Channel | Direction | Handshake                | Beat
// input   | in        | in_valid_i / in_ready_o  | lex_in_t: one character or the end mark
// output  | out       | out_valid_o / out_ready_i| lex_out_t: one token or error report
//
// The scanner takes one character a cycle whenever the bundle queue has room.
// A character yields up to three tokens, sent one beat a cycle by the output register if ready.
// Throughput is one character a cycle if characters average at most one token, output unstalled.
// Reset is asynchronous and active low; it clears the scanner state and empties the queue.
// A stalled output holds its beat while the scanner goes on until the two-entry queue fills.
module source_lexer_core #(
  parameter int unsigned KeywordMaxLen = slx_pkg::KEYWORD_MAX_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slx_pkg::lex_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slx_pkg::lex_out_t out_data_o
);
  import slx_pkg::*;

  logic    full, push, pop, head_valid;
  bundle_t bundle, head;

  assign in_ready_o = !full;

  slx_front #(.KeywordMaxLen(KeywordMaxLen)) u_front (
    .clk_i, .rst_ni,
    .take_i   (in_valid_i && !full),
    .data_i   (in_data_i),
    .push_o   (push),
    .bundle_o (bundle)
  );

  slx_queue u_queue (
    .clk_i, .rst_ni,
    .push_i       (push),
    .push_data_i  (bundle),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  slx_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ===== rtl/core/slx_front.sv =====
module slx_front #(
  parameter int unsigned KeywordMaxLen = slx_pkg::KEYWORD_MAX_LEN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  slx_pkg::lex_in_t data_i,
  output logic             push_o,
  output slx_pkg::bundle_t bundle_o
);
  import slx_pkg::*;

  localparam int unsigned LW = $clog2(KeywordMaxLen + 2);
  localparam int unsigned IW = $clog2(KeywordMaxLen);

  mode_e                mode_q, mode_d;
  logic [7:0]           pend_q, pend_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d, ts_q, ts_d, line_q, line_d;
  logic [KeywordMaxLen-1:0][7:0] id_q, id_d;
  logic [LW-1:0]        idlen_q, idlen_d;
  logic [INT_BITS-1:0]  acc_q, acc_d;
  logic                 sat_q, sat_d;

  lex_out_t             r [MAX_SLOTS];
  logic [1:0]           n;
  logic                 cons, do_flush;
  logic [7:0]           c;
  logic [POS_WIDTH-1:0] p, len;
  logic [5:0]           id_kind;
  logic [INT_BITS+3:0]  prod;

  function automatic lex_out_t mk(logic [5:0] k, logic [POS_WIDTH-1:0] s,
                                  logic [POS_WIDTH-1:0] l, logic [POS_WIDTH-1:0] ln,
                                  logic [INT_BITS-1:0] v, logic o, logic [1:0] e);
    lex_out_t t;
    t.token_kind = k;
    t.start_pos = s;
    t.lexeme_length = l;
    t.line_number = ln;
    t.int_value = v;
    t.value_overflow = o;
    t.error_code = e;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic hit;
    hit = 1'b0;
    id_kind = K_IDENT;
    if (idlen_q <= LW'(KeywordMaxLen)) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        hit = (idlen_q == LW'(KW_LEN[i]));
        for (int j = 0; j < 6; j++) begin
          if (j < int'(KW_LEN[i]) && j < int'(KeywordMaxLen)) begin
            if (id_q[j] != kw_byte(i, j)) hit = 1'b0;
          end
        end
        if (hit) id_kind = K_KW0 + 6'(i);
      end
    end
  end

  always_comb begin
    c = data_i.char_code;
    p = pos_q;
    len = p - ts_q;
    mode_d = mode_q;
    pend_d = pend_q;
    pos_d = p + POS_WIDTH'(1);
    ts_d = ts_q;
    line_d = line_q;
    id_d = id_q;
    idlen_d = idlen_q;
    acc_d = acc_q;
    sat_d = sat_q;
    n = '0;
    for (int i = 0; i < MAX_SLOTS; i++) r[i] = '0;
    cons = 1'b0;
    do_flush = 1'b0;
    prod = '0;

    if (data_i.end_of_source) begin
      if (mode_q == M_STRING) begin
        r[n] = mk(K_ERROR, ts_q + POS_WIDTH'(1), len - POS_WIDTH'(1), line_q, '0, 1'b0,
                  ERR_UNTERM);
        n = n + 2'd1;
      end else begin
        do_flush = 1'b1;
      end
    end else begin
      unique case (mode_q)
        M_OP: begin
          if (c == CH_EQUAL && pend_q != CH_SLASH) begin
            r[n] = mk(op_kind(pend_q) + 6'd1, ts_q, POS_WIDTH'(2), line_q, '0, 1'b0,
                      ERR_NONE);
            n = n + 2'd1;
            mode_d = M_IDLE;
            cons = 1'b1;
          end else if (c == CH_SLASH && pend_q == CH_SLASH) begin
            mode_d = M_COMMENT;
            cons = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) mode_d = M_IDLE;
          else cons = 1'b1;
        end
        M_STRING: begin
          cons = 1'b1;
          if (c == CH_QUOTE) begin
            r[n] = mk(K_STRING, ts_q + POS_WIDTH'(1), len - POS_WIDTH'(1), line_q, '0,
                      1'b0, ERR_NONE);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else if (c == CH_NL && line_q < LINE_MAX) begin
            line_d = line_q + POS_WIDTH'(1);
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (INT_BITS+4)'(c - 8'h30);
            if (sat_q || prod > (INT_BITS+4)'(INT_MAX_VAL)) begin
              acc_d = INT_MAX_VAL;
              sat_d = 1'b1;
            end else begin
              acc_d = prod[INT_BITS-1:0];
            end
            cons = 1'b1;
          end else if (c == CH_DOT) begin
            mode_d = M_INT_DOT;
            cons = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(c)) begin
            mode_d = M_FRAC;
            cons = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) cons = 1'b1;
          else do_flush = 1'b1;
        end
        M_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            if (idlen_q < LW'(KeywordMaxLen)) id_d[idlen_q[IW-1:0]] = c;
            if (idlen_q <= LW'(KeywordMaxLen)) idlen_d = idlen_q + LW'(1);
            cons = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: mode_d = M_IDLE;
      endcase
    end

    if (do_flush) begin
      unique case (mode_q)
        M_OP: begin
          r[n] = mk(op_kind(pend_q), ts_q, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end
        M_INT: begin
          r[n] = mk(K_INTEGER, ts_q, len, line_q, acc_q, sat_q, ERR_NONE);
          n = n + 2'd1;
        end
        M_INT_DOT: begin
          r[n] = mk(K_INTEGER, ts_q, len - POS_WIDTH'(1), line_q, acc_q, sat_q, ERR_NONE);
          n = n + 2'd1;
          r[n] = mk(K_DOT, p - POS_WIDTH'(1), POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end
        M_FRAC: begin
          r[n] = mk(K_FLOAT, ts_q, len, line_q, '0, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end
        M_IDENT: begin
          r[n] = mk(id_kind, ts_q, len, line_q, '0, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
    end

    if (data_i.end_of_source) begin
      r[n] = mk(K_END, p, '0, line_q, '0, 1'b0, ERR_NONE);
      n = n + 2'd1;
      mode_d = M_IDLE;
      pend_d = '0;
      pos_d = '0;
      ts_d = '0;
      line_d = POS_WIDTH'(1);
      id_d = '0;
      idlen_d = '0;
      acc_d = '0;
      sat_d = 1'b0;
    end else if (!cons) begin
      ts_d = p;
      case (c)
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT, CH_MINUS,
        CH_PLUS, CH_SEMI, CH_STAR: begin
          case (c)
            CH_LPAREN: r[n] = mk(K_LPAREN, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_RPAREN: r[n] = mk(K_RPAREN, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_LBRACE: r[n] = mk(K_LBRACE, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_RBRACE: r[n] = mk(K_RBRACE, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_COMMA:  r[n] = mk(K_COMMA, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_DOT:    r[n] = mk(K_DOT, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_MINUS:  r[n] = mk(K_MINUS, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_PLUS:   r[n] = mk(K_PLUS, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            CH_SEMI:   r[n] = mk(K_SEMI, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
            default:   r[n] = mk(K_STAR, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_NONE);
          endcase
          n = n + 2'd1;
        end
        CH_BANG, CH_EQUAL, CH_LESS, CH_GREAT, CH_SLASH: begin
          pend_d = c;
          mode_d = M_OP;
        end
        CH_SPACE, CH_CR, CH_TAB: ;
        CH_NL: begin
          if (line_q < LINE_MAX) line_d = line_q + POS_WIDTH'(1);
        end
        CH_QUOTE: mode_d = M_STRING;
        default: begin
          if (is_digit(c)) begin
            acc_d = INT_BITS'(c - 8'h30);
            sat_d = 1'b0;
            mode_d = M_INT;
          end else if (is_alpha(c)) begin
            id_d[0] = c;
            idlen_d = LW'(1);
            mode_d = M_IDENT;
          end else begin
            r[n] = mk(K_ERROR, p, POS_WIDTH'(1), line_q, '0, 1'b0, ERR_CHAR);
            n = n + 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    bundle_o.count = n;
    for (int i = 0; i < MAX_SLOTS; i++) bundle_o.slots[i] = r[i];
    push_o = take_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      pos_q <= '0;
      ts_q <= '0;
      line_q <= POS_WIDTH'(1);
      id_q <= '0;
      idlen_q <= '0;
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      pos_q <= pos_d;
      ts_q <= ts_d;
      line_q <= line_d;
      id_q <= id_d;
      idlen_q <= idlen_d;
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

endmodule

// ===== rtl/core/slx_queue.sv =====
module slx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slx_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output slx_pkg::bundle_t head_o
);
  import slx_pkg::*;

  bundle_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/core/slx_back.sv =====
module slx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  slx_pkg::bundle_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slx_pkg::lex_out_t out_data_o
);
  import slx_pkg::*;

  logic [1:0] k_q;
  logic       load, last;
  lex_out_t   out_q;
  lex_out_t   slot;
  logic       valid_q;

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign last  = (k_q == head_i.count - 2'd1);
  assign pop_o = load && last;

  always_comb begin
    slot = head_i.slots[k_q];
    slot.last_of_run = last;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) k_q <= last ? 2'd0 : k_q + 2'd1;
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  a_pop_has_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i) else $error("pop without a bundle");
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> head_i.count != 2'd0) else $error("empty bundle queued");
  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> k_q < head_i.count) else $error("slot index overrun");
  a_pop_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> k_q == 2'd0) else $error("slot index not cleared");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import slx_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_COMMENT, S_STRING, S_INT, S_INT_DOT, S_FRAC, S_IDENT
  } scan_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  lex_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  lex_out_t out_data_o;

  source_lexer_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  lex_in_t  char_queue[$];
  lex_out_t token_queue[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned mismatches = 0;
  int unsigned tokens_seen = 0;
  int unsigned chars_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_pause = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  bit          in_fire = 1'b0;

  scan_e                 lx_mode;
  logic [7:0]            lx_op;
  logic [POS_WIDTH-1:0]  lx_pos;
  logic [POS_WIDTH-1:0]  lx_start;
  logic [POS_WIDTH-1:0]  lx_line;
  logic [7:0]            lx_id [KEYWORD_MAX_LEN];
  int unsigned           lx_id_len;
  logic [INT_BITS-1:0]   lx_acc;
  logic                  lx_sat;

  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic lexer_clear();
    lx_mode = S_IDLE; lx_op = '0; lx_pos = '0; lx_start = '0; lx_line = POS_WIDTH'(1);
    foreach (lx_id[i]) lx_id[i] = '0;
    lx_id_len = 0; lx_acc = '0; lx_sat = 1'b0;
  endtask

  task automatic push_token(ref lex_out_t toks[$], input logic [5:0] kind,
                            input logic [POS_WIDTH-1:0] st, input logic [POS_WIDTH-1:0] len,
                            input logic [INT_BITS-1:0] val, input logic ovf,
                            input logic [1:0] err);
    lex_out_t t;
    t.token_kind = kind; t.start_pos = st; t.lexeme_length = len;
    t.line_number = lx_line; t.int_value = val; t.value_overflow = ovf;
    t.error_code = err; t.last_of_run = 1'b0;
    toks = {toks, t};
  endtask

  function automatic logic [5:0] single_kind(logic [7:0] op);
    case (op)
      "!": return K_BANG;
      "=": return K_EQUAL;
      ">": return K_GREATER;
      "<": return K_LESS;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    string kw [20] = '{"and", "class", "else", "false", "for", "fun", "if", "NOV", "or",
                       "print", "return", "super", "this", "self", "true", "bool", "int",
                       "float", "string", "while"};
    bit hit;
    if (lx_id_len > KEYWORD_MAX_LEN) return K_IDENT;
    for (int k = 0; k < 20; k++) begin
      if (kw[k].len() == lx_id_len) begin
        hit = 1'b1;
        for (int j = 0; j < lx_id_len; j++) if (kw[k][j] != lx_id[j]) hit = 1'b0;
        if (hit) return K_KW0 + 6'(k);
      end
    end
    return K_IDENT;
  endfunction

  task automatic add_digit(logic [7:0] c);
    logic [INT_BITS:0] d;
    d = c - "0";
    if (lx_sat || {1'b0, lx_acc} > ({1'b0, INT_MAX_VAL} - d) / 10) begin
      lx_acc = INT_MAX_VAL; lx_sat = 1'b1;
    end else begin
      lx_acc = lx_acc * 10 + d[INT_BITS-1:0];
    end
  endtask

  task automatic flush_pending(ref lex_out_t toks[$], input logic [POS_WIDTH-1:0] p);
    logic [POS_WIDTH-1:0] len;
    len = p - lx_start;
    case (lx_mode)
      S_OP:      push_token(toks, single_kind(lx_op), lx_start, 1, 0, 0, ERR_NONE);
      S_INT:     push_token(toks, K_INTEGER, lx_start, len, lx_acc, lx_sat, ERR_NONE);
      S_INT_DOT: begin
        push_token(toks, K_INTEGER, lx_start, len - 1, lx_acc, lx_sat, ERR_NONE);
        push_token(toks, K_DOT, p - 1, 1, 0, 0, ERR_NONE);
      end
      S_FRAC:    push_token(toks, K_FLOAT, lx_start, len, 0, 0, ERR_NONE);
      S_IDENT:   push_token(toks, word_kind(), lx_start, len, 0, 0, ERR_NONE);
      default: ;
    endcase
    lx_mode = S_IDLE;
  endtask

  task automatic begin_char(ref lex_out_t toks[$], input logic [7:0] c,
                            input logic [POS_WIDTH-1:0] p);
    lx_start = p;
    case (c)
      "(": push_token(toks, K_LPAREN, p, 1, 0, 0, ERR_NONE);
      ")": push_token(toks, K_RPAREN, p, 1, 0, 0, ERR_NONE);
      "{": push_token(toks, K_LBRACE, p, 1, 0, 0, ERR_NONE);
      "}": push_token(toks, K_RBRACE, p, 1, 0, 0, ERR_NONE);
      ",": push_token(toks, K_COMMA, p, 1, 0, 0, ERR_NONE);
      ".": push_token(toks, K_DOT, p, 1, 0, 0, ERR_NONE);
      "-": push_token(toks, K_MINUS, p, 1, 0, 0, ERR_NONE);
      "+": push_token(toks, K_PLUS, p, 1, 0, 0, ERR_NONE);
      ";": push_token(toks, K_SEMI, p, 1, 0, 0, ERR_NONE);
      "*": push_token(toks, K_STAR, p, 1, 0, 0, ERR_NONE);
      "!", "=", "<", ">", "/": begin
        lx_op = c; lx_mode = S_OP;
      end
      CH_SPACE, CH_CR, CH_TAB: ;
      CH_NL: if (lx_line != LINE_MAX) lx_line++;
      CH_QUOTE: lx_mode = S_STRING;
      default: begin
        if (ch_digit(c)) begin
          lx_acc = '0; lx_sat = 1'b0; add_digit(c); lx_mode = S_INT;
        end else if (ch_alpha(c)) begin
          lx_id[0] = c; lx_id_len = 1; lx_mode = S_IDENT;
        end else begin
          push_token(toks, K_ERROR, p, 1, 0, 0, ERR_CHAR);
        end
      end
    endcase
  endtask

  task automatic predict_tokens(input lex_in_t beat);
    lex_out_t toks[$];
    logic [7:0] c;
    logic [POS_WIDTH-1:0] p;
    bit used;
    c = beat.char_code; p = lx_pos; used = 1'b0;
    if (beat.end_of_source) begin
      if (lx_mode == S_STRING)
        push_token(toks, K_ERROR, lx_start + 1, p - lx_start - 1, 0, 0, ERR_UNTERM);
      else
        flush_pending(toks, p);
      push_token(toks, K_END, p, 0, 0, 0, ERR_NONE);
      lexer_clear();
    end else begin
      case (lx_mode)
        S_OP: begin
          if (c == "=" && lx_op != "/") begin
            push_token(toks, single_kind(lx_op) + 1, lx_start, 2, 0, 0, ERR_NONE);
            lx_mode = S_IDLE; used = 1'b1;
          end else if (c == "/" && lx_op == "/") begin
            lx_mode = S_COMMENT; used = 1'b1;
          end else begin
            flush_pending(toks, p);
          end
        end
        S_COMMENT: if (c == CH_NL) lx_mode = S_IDLE; else used = 1'b1;
        S_STRING: begin
          used = 1'b1;
          if (c == CH_QUOTE) begin
            push_token(toks, K_STRING, lx_start + 1, p - lx_start - 1, 0, 0, ERR_NONE);
            lx_mode = S_IDLE;
          end else if (c == CH_NL && lx_line != LINE_MAX) begin
            lx_line++;
          end
        end
        S_INT: begin
          if (ch_digit(c)) begin
            add_digit(c); used = 1'b1;
          end else if (c == CH_DOT) begin
            lx_mode = S_INT_DOT; used = 1'b1;
          end else begin
            flush_pending(toks, p);
          end
        end
        S_INT_DOT: if (ch_digit(c)) begin
          lx_mode = S_FRAC; used = 1'b1;
        end else begin
          flush_pending(toks, p);
        end
        S_FRAC: if (ch_digit(c)) used = 1'b1; else flush_pending(toks, p);
        S_IDENT: begin
          if (ch_digit(c) || ch_alpha(c)) begin
            if (lx_id_len < KEYWORD_MAX_LEN) lx_id[lx_id_len] = c;
            if (lx_id_len <= KEYWORD_MAX_LEN) lx_id_len++;
            used = 1'b1;
          end else begin
            flush_pending(toks, p);
          end
        end
        default: lx_mode = S_IDLE;
      endcase
      if (!used) begin_char(toks, c, p);
      lx_pos = p + 1;
    end
    if (toks.size() > 0) toks[toks.size()-1].last_of_run = 1'b1;
    foreach (toks[i]) token_queue = {token_queue, toks[i]};
  endtask

  task automatic queue_byte(input logic [7:0] c);
    lex_in_t b;
    b.char_code = c; b.end_of_source = 1'b0;
    char_queue = {char_queue, b};
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_end();
    lex_in_t b;
    b.char_code = 8'($urandom); b.end_of_source = 1'b1;
    char_queue = {char_queue, b};
  endtask

  task automatic queue_fragment();
    string frags [24] = '{"while", "x1 ", "return ", "12.5 ", "7.", "7.x", "\"hi\nyo\"",
                          "// note\n", "a!=b", "c==d", "e<=f", "g>=h", "/ ", "print(",
                          "){},", "-+;*", "\n", " \t\r", "4294967296 ", "supercalif ",
                          "float ", "self.this", "bool=int", "string"};
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      queue_text(frags[$urandom_range(0, 23)]);
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid_i || token_queue.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i) in_fire <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (char_queue.size() != 0 && !sender_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= char_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      recv_hold   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
    end else if (recv_hold != 0) begin
      out_ready_i <= 1'b0;
      recv_hold   <= recv_hold - 1;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lex_out_t want;
    if (!rst_ni) begin
      lexer_clear();
    end else begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        predict_tokens(in_data_i);
        chars_sent <= chars_sent + 1;
      end
      if (out_valid_o && out_ready_i) begin
        tokens_seen <= tokens_seen + 1;
        if (token_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected token beat %p", out_data_o);
        end else begin
          want = token_queue.pop_front();
          if (out_data_o !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("token beat mismatch: expected %p actual %p",
                                          want, out_data_o);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d tokens pending", token_queue.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned idle_tab [4] = '{0, 53, 0, 22};
    int unsigned stall_tab [4] = '{0, 0, 53, 22};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_text("(){},.-+;*!a=b>c<d!=e==f>=g<=h/ ");
    queue_text("2147483648 12.34 5.a // c\n\"a\nb\"");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte("@");
    queue_end();
    queue_text("\"op");
    queue_end();
    queue_text("7.");
    queue_end();
    queue_end();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 1) begin
        hold_req = 1'b1;
        queue_text("a,b,c,d,e;");
      end
      for (int k = 0; k < 2; k++) queue_fragment();
      queue_end();
      wait_drained();
    end

    send_idle_pct = 10; recv_stall_pct = 10;
    for (int k = 0; k < 3; k++) queue_fragment();
    repeat (4) @(posedge clk_i);
    sender_pause = 1'b1;
    while (in_valid_i || token_queue.size() != 0) @(posedge clk_i);
    sender_pause = 1'b0;
    for (int k = 0; k < 2; k++) queue_fragment();
    queue_end();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters and end marks, checked %0d token beats.",
             chars_sent, tokens_seen);
    $display("Covered operators, literals, errors, keywords and back-pressure phases.");
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
